// ===== src/pmpd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the PS/2 mouse packet decoder: packet and queue types,
// header bit positions, direction codes and output packing widths.
// No dependencies.
package pmpd_pkg;

    // Header bit positions
    localparam int unsigned HDR_LEFT   = 0;
    localparam int unsigned HDR_RIGHT  = 1;
    localparam int unsigned HDR_MIDDLE = 2;
    localparam int unsigned HDR_SIGN_X = 4;
    localparam int unsigned HDR_SIGN_Y = 5;
    localparam int unsigned HDR_OVF_X  = 6;
    localparam int unsigned HDR_OVF_Y  = 7;

    // Direction codes
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_POS  = 2'd1;
    localparam logic [1:0] DIR_NEG  = 2'd2;

    // Packet queue between front and back
    localparam int unsigned QDEPTH  = 2;
    localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

    localparam int unsigned OUT_TDATA_W = 32;

    typedef struct packed {
        logic [7:0] y_byte;
        logic [7:0] x_byte;
        logic [7:0] header;
    } t_pkt;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic [8:0] y_amount;
        logic [1:0] y_direction;
        logic [8:0] x_amount;
        logic [1:0] x_direction;
        logic       middle_pressed;
        logic       right_pressed;
        logic       left_pressed;
        logic       dropped;
    } t_result;

endpackage

// ===== src/pmpd_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts received bytes, tracks the byte position within the
// three-byte packet and pushes whole packets into the queue. Uses pmpd_pkg.
module pmpd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_byte,
    input  pmpd_pkg::t_q_stat i_q_stat,
    output logic              o_push,
    output pmpd_pkg::t_pkt    o_pkt
);

    localparam logic [1:0] POS_HEADER = 2'd0;
    localparam logic [1:0] POS_X      = 2'd1;
    localparam logic [1:0] POS_Y      = 2'd2;

    logic [1:0] r_pos;
    logic [1:0] n_pos;
    logic [7:0] r_header;
    logic [7:0] r_x_byte;
    logic       w_accept;

    // Only the closing byte needs queue room
    assign o_ready  = (r_pos != POS_Y) || !i_q_stat.full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept && (r_pos == POS_Y);

    assign o_pkt.header = r_header;
    assign o_pkt.x_byte = r_x_byte;
    assign o_pkt.y_byte = i_byte;

    always_comb begin
        n_pos = r_pos;
        if (w_accept) begin
            case (r_pos)
                POS_X:   n_pos = POS_Y;
                POS_Y:   n_pos = POS_HEADER;
                default: n_pos = POS_X;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HEADER;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (r_pos == POS_X)) begin
            r_x_byte <= i_byte;
        end
        if (w_accept && (r_pos != POS_X) && (r_pos != POS_Y)) begin
            r_header <= i_byte;
        end
    end

`ifndef SYNTHESIS
    a_pos_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos != 2'd3) else $error("front: unused byte position reached");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_stat.full) else $error("front: push into full queue");
    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> r_pos == POS_HEADER) else $error("front: no restart after packet");
`endif

endmodule

// ===== src/pmpd_fifo.sv =====
`timescale 1ns / 1ps
// Short packet queue that decouples the byte front end from the result
// stage. Uses pmpd_pkg for depth and packet type.
module pmpd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pmpd_pkg::t_pkt    i_pkt,
    input  logic              i_pop,
    output pmpd_pkg::t_pkt    o_pkt,
    output pmpd_pkg::t_q_stat o_stat
);

    pmpd_pkg::t_pkt                   r_mem [pmpd_pkg::QDEPTH];
    logic [pmpd_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [pmpd_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [pmpd_pkg::QCNT_W-1:0]      r_count;

    localparam logic [pmpd_pkg::QPTR_W-1:0] PTR_LAST =
        pmpd_pkg::QPTR_W'(pmpd_pkg::QDEPTH - 1);
    localparam logic [pmpd_pkg::QCNT_W-1:0] CNT_FULL =
        pmpd_pkg::QCNT_W'(pmpd_pkg::QDEPTH);

    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.empty = (r_count == '0);
    assign o_pkt        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL) else $error("fifo: count beyond depth");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty) else $error("fifo: pop from empty queue");
    a_cnt_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("fifo: count did not advance on push");
`endif

endmodule

// ===== src/pmpd_back.sv =====
`timescale 1ns / 1ps
// Back end: decodes one queued packet into buttons, directions and
// magnitudes, and holds it in the output register. Uses pmpd_pkg.
module pmpd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pmpd_pkg::t_pkt    i_pkt,
    input  pmpd_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output pmpd_pkg::t_result o_result
);

    logic               r_valid;
    pmpd_pkg::t_result  r_result;
    pmpd_pkg::t_result  w_dec;
    logic               w_ovf;
    logic               w_neg_x;
    logic               w_neg_y;

    assign o_pop    = !i_q_stat.empty && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    assign w_ovf   = i_pkt.header[pmpd_pkg::HDR_OVF_X] || i_pkt.header[pmpd_pkg::HDR_OVF_Y];
    assign w_neg_x = i_pkt.header[pmpd_pkg::HDR_SIGN_X];
    assign w_neg_y = i_pkt.header[pmpd_pkg::HDR_SIGN_Y];

    always_comb begin
        w_dec = '0;
        if (w_ovf) begin
            w_dec.dropped = 1'b1;
        end else begin
            w_dec.left_pressed   = i_pkt.header[pmpd_pkg::HDR_LEFT];
            w_dec.right_pressed  = i_pkt.header[pmpd_pkg::HDR_RIGHT];
            w_dec.middle_pressed = i_pkt.header[pmpd_pkg::HDR_MIDDLE];
            // Negative delta: magnitude is 256 minus the byte
            if (w_neg_x) begin
                w_dec.x_direction = pmpd_pkg::DIR_NEG;
                w_dec.x_amount    = 9'd256 - {1'b0, i_pkt.x_byte};
            end else if (i_pkt.x_byte != 8'd0) begin
                w_dec.x_direction = pmpd_pkg::DIR_POS;
                w_dec.x_amount    = {1'b0, i_pkt.x_byte};
            end
            if (w_neg_y) begin
                w_dec.y_direction = pmpd_pkg::DIR_NEG;
                w_dec.y_amount    = 9'd256 - {1'b0, i_pkt.y_byte};
            end else if (i_pkt.y_byte != 8'd0) begin
                w_dec.y_direction = pmpd_pkg::DIR_POS;
                w_dec.y_amount    = {1'b0, i_pkt.y_byte};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= w_dec;
        end
    end

`ifndef SYNTHESIS
    a_drop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_result.dropped) |->
        (!r_result.left_pressed && !r_result.right_pressed && !r_result.middle_pressed
         && r_result.x_amount == 9'd0 && r_result.y_amount == 9'd0
         && r_result.x_direction == pmpd_pkg::DIR_NONE
         && r_result.y_direction == pmpd_pkg::DIR_NONE))
        else $error("back: dropped packet carries movement or buttons");
    a_dir_amt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ((r_result.x_direction == pmpd_pkg::DIR_NONE) == (r_result.x_amount == 9'd0)))
        else $error("back: x direction and amount disagree");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_result)))
        else $error("back: stalled result changed");
`endif

endmodule

// ===== src/ps2_mouse_packet_decoder_top.sv =====
`timescale 1ns / 1ps
// Top level of the PS/2 mouse packet decoder: front end, packet queue and
// back end. Uses pmpd_pkg, pmpd_front, pmpd_fifo and pmpd_back.
//
// Feed the bytes received from a PS/2 mouse, one item per byte, on the
// s_axis side; every third byte closes a packet (header, x delta, y delta)
// and one result item leaves on the m_axis side. The block accepts one byte
// per clock cycle. Once its closing byte is accepted, the packet lands in
// the two-entry queue, and the back end decodes it from there into the
// output register once that register is free or being read. Header and x
// bytes are never stalled; the closing byte waits only while the queue is
// full, which takes a downstream stall. A packet with either overflow bit
// set yields dropped = 1 with every other field zero. Otherwise each axis
// is the 9-bit signed delta (sign bit in the header) given as a direction
// (0 none, 1 right/up, 2 left/down) and a magnitude of 0 to 256; a zero
// byte with its sign bit set reads as 256 in the negative direction.
// The byte position restarts at the header after reset.
module ps2_mouse_packet_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] dropped, [1] left_pressed, [2] right_pressed, [3] middle_pressed,
    // [5:4] x_direction, [14:6] x_amount, [16:15] y_direction,
    // [25:17] y_amount, [31:26] zero
    output logic [pmpd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    pmpd_pkg::t_q_stat w_q_stat;
    pmpd_pkg::t_pkt    w_push_pkt;
    pmpd_pkg::t_pkt    w_head_pkt;
    pmpd_pkg::t_result w_result;
    logic              w_push;
    logic              w_pop;

    // Gather bytes into packets
    pmpd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_byte   (s_axis_tdata),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_pkt    (w_push_pkt)
    );

    // Hold whole packets until the back end takes them
    pmpd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pkt   (w_push_pkt),
        .i_pop   (w_pop),
        .o_pkt   (w_head_pkt),
        .o_stat  (w_q_stat)
    );

    // Decode and register the result
    pmpd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pkt    (w_head_pkt),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_result)
    );

    // Pad the packed result up to whole bytes
    assign m_axis_tdata = {{(pmpd_pkg::OUT_TDATA_W - $bits(w_result)){1'b0}}, w_result};

endmodule

// ===== tb/ps2_mouse_packet_checker.sv =====
`timescale 1ns / 1ps
// Checker for the PS/2 mouse packet decoder: watches both stream channels,
// predicts each decoded packet and compares it field by field.
// Depends on pmpd_pkg for the result layout, header bits and direction codes.
module ps2_mouse_packet_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_byte_tvalid,
    input  logic                             i_byte_tready,
    input  logic [7:0]                       i_byte_tdata,
    input  logic                             i_move_tvalid,
    input  logic                             i_move_tready,
    input  logic [pmpd_pkg::OUT_TDATA_W-1:0] i_move_tdata,
    input  logic                             i_end_of_test,
    output int unsigned                      o_fail_count,
    output int unsigned                      o_pending
);

    typedef enum logic [1:0] {WANT_HEADER, WANT_X, WANT_Y} t_slot;
    localparam int unsigned MOVE_W = $bits(pmpd_pkg::t_result);

    t_slot             slot = WANT_HEADER;
    logic [7:0]        held_header = '0;
    logic [7:0]        held_x = '0;
    pmpd_pkg::t_result expected_moves[$];
    int unsigned       fail_count = 0;
    int unsigned       bytes_seen = 0;
    int unsigned       packets_checked = 0;
    int unsigned       dropped_seen = 0;
    int unsigned       full_scale_seen = 0;
    bit                closed = 1'b0;

    assign o_fail_count = fail_count;

    // 9-bit signed delta {sign, raw} as direction and magnitude
    function automatic logic [10:0] axis_motion(input logic [7:0] raw, input logic negative);
        if (negative)
            return {pmpd_pkg::DIR_NEG, 9'd256 - {1'b0, raw}};
        else if (raw != 8'd0)
            return {pmpd_pkg::DIR_POS, 1'b0, raw};
        return {pmpd_pkg::DIR_NONE, 9'd0};
    endfunction

    function automatic pmpd_pkg::t_result decode_packet(input logic [7:0] hdr,
                                                        input logic [7:0] xb,
                                                        input logic [7:0] yb);
        pmpd_pkg::t_result r;
        r = '0;
        if (hdr[pmpd_pkg::HDR_OVF_X] || hdr[pmpd_pkg::HDR_OVF_Y]) begin
            r.dropped = 1'b1;
            return r;
        end
        r.left_pressed   = hdr[pmpd_pkg::HDR_LEFT];
        r.right_pressed  = hdr[pmpd_pkg::HDR_RIGHT];
        r.middle_pressed = hdr[pmpd_pkg::HDR_MIDDLE];
        {r.x_direction, r.x_amount} = axis_motion(xb, hdr[pmpd_pkg::HDR_SIGN_X]);
        {r.y_direction, r.y_amount} = axis_motion(yb, hdr[pmpd_pkg::HDR_SIGN_Y]);
        return r;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        pmpd_pkg::t_result want;
        pmpd_pkg::t_result got;
        if (!i_rst_n) begin
            slot        = WANT_HEADER;
            held_header = '0;
            held_x      = '0;
            expected_moves.delete();
        end else begin
            if (i_byte_tvalid && i_byte_tready) begin
                bytes_seen++;
                case (slot)
                    WANT_X: begin
                        held_x = i_byte_tdata;
                        slot   = WANT_Y;
                    end
                    WANT_Y: begin
                        expected_moves.push_back(decode_packet(held_header, held_x,
                                                               i_byte_tdata));
                        slot = WANT_HEADER;
                    end
                    default: begin
                        held_header = i_byte_tdata;
                        slot        = WANT_X;
                    end
                endcase
            end
            if (i_move_tvalid && i_move_tready) begin
                got = pmpd_pkg::t_result'(i_move_tdata[MOVE_W-1:0]);
                if (expected_moves.size() == 0) begin
                    $error("result item %h arrived with no packet pending", i_move_tdata);
                    fail_count++;
                end else begin
                    want = expected_moves.pop_front();
                    packets_checked++;
                    if (want.dropped)
                        dropped_seen++;
                    if (want.x_amount == 9'd256 || want.y_amount == 9'd256)
                        full_scale_seen++;
                    compare_field("dropped", want.dropped, got.dropped);
                    compare_field("left_pressed", want.left_pressed, got.left_pressed);
                    compare_field("right_pressed", want.right_pressed, got.right_pressed);
                    compare_field("middle_pressed", want.middle_pressed, got.middle_pressed);
                    compare_field("x_direction", want.x_direction, got.x_direction);
                    compare_field("x_amount", want.x_amount, got.x_amount);
                    compare_field("y_direction", want.y_direction, got.y_direction);
                    compare_field("y_amount", want.y_amount, got.y_amount);
                    compare_field("tdata padding", 0,
                                  i_move_tdata[pmpd_pkg::OUT_TDATA_W-1:MOVE_W]);
                end
            end
            if (i_end_of_test && !closed) begin
                closed = 1'b1;
                if (expected_moves.size() != 0) begin
                    $error("%0d decoded packets never came out", expected_moves.size());
                    fail_count += expected_moves.size();
                end
                $display("Decoded %0d packets from %0d bytes: %0d dropped on overflow,",
                         packets_checked, bytes_seen, dropped_seen);
                $display("%0d with an axis at full scale 256.", full_scale_seen);
            end
        end
        o_pending <= expected_moves.size();
    end

endmodule

// ===== tb/ps2_mouse_packet_decoder_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the PS/2 mouse packet decoder: clock, reset, byte
// stimulus, result back-pressure and the verdict.
// Depends on pmpd_pkg, ps2_mouse_packet_decoder_top and ps2_mouse_packet_checker.
module ps2_mouse_packet_decoder_top_tb;

    localparam int unsigned RANDOM_PACKETS = 334;  // about 1000 bytes
    localparam int unsigned RUSH_BYTES     = 30;   // back-to-back bytes during a long stall
    localparam int unsigned LONG_STALL     = 60;   // cycles the receiver holds off

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [7:0]                       s_axis_tdata;   // [7:0] rx_byte
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    // [0] dropped, [1] left, [2] right, [3] middle, [5:4] x_direction,
    // [14:6] x_amount, [16:15] y_direction, [25:17] y_amount, [31:26] zero
    logic [pmpd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             end_of_test;
    int unsigned                      fail_count;
    int unsigned                      pending;

    // Long-stall handshake between stimulus and receiver: the sender bumps
    // the request count, the receiver serves one hold per request.
    int unsigned            stall_asked = 0;
    int unsigned            stall_done = 0;
    int unsigned            burst_left = 0;

    ps2_mouse_packet_decoder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ps2_mouse_packet_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_byte_tvalid  (s_axis_tvalid),
        .i_byte_tready  (s_axis_tready),
        .i_byte_tdata   (s_axis_tdata),
        .i_move_tvalid  (m_axis_tvalid),
        .i_move_tready  (m_axis_tready),
        .i_move_tdata   (m_axis_tdata),
        .i_end_of_test  (end_of_test),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Hard limit: far beyond the slowest legal run
    initial begin
        #5ms;
        $display("FAIL ps2_mouse_packet_decoder_top");
        $finish;
    end

    // Offer one byte, holding it until the block takes it. Outside a rush the
    // sender works in bursts; at the end of a burst drop tvalid for a random
    // gap. Sample tready mid-cycle, where it is settled, and count the item
    // as taken at the following rising edge. Called and returns at a rising edge.
    task automatic offer_byte(input logic [7:0] b, input bit rush);
        bit took;
        if (!rush && burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = s_axis_tready;
            @(posedge i_clk);
        end
        if (burst_left > 0)
            burst_left--;
    endtask

    // Pause the sender until every decoded packet has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Delta byte with the edges weighted up: zero, all ones, one, and 0x80
    function automatic logic [7:0] pick_delta();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h01;
            3:       return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    // Receiver: a long hold on request, otherwise one of four stall patterns
    // picked for a random stretch: always ready, coin flip, periodic window,
    // and mostly stalled.
    initial begin : receiver
        int unsigned mode;
        int unsigned mode_left;
        int unsigned cyc;
        mode      = 0;
        mode_left = 0;
        cyc       = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (stall_asked != stall_done) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge i_clk);
                stall_done = stall_done + 1;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom);
                    2:       m_axis_tready <= ((cyc % 5) < 2);
                    default: m_axis_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        logic [7:0]  directed[$];
        logic [7:0]  hdr;
        int unsigned rush_left;
        int unsigned spins;
        // Directed packets, header / x / y:
        //   zero motion; all buttons with smallest and largest positive deltas;
        //   negative zero on both axes (reads as 256); -255 and -1;
        //   x overflow; y overflow; both overflows with everything else set;
        //   right button with x sign and 0x80 deltas.
        directed = '{8'h08, 8'h00, 8'h00,
                     8'h0F, 8'h01, 8'hFF,
                     8'h38, 8'h00, 8'h00,
                     8'h39, 8'h01, 8'hFF,
                     8'h4F, 8'h7F, 8'h80,
                     8'h87, 8'h10, 8'hF0,
                     8'hFF, 8'hFF, 8'hFF,
                     8'h12, 8'h80, 8'h80};

        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        end_of_test   = 1'b0;
        i_rst_n       = 1'b0;
        rush_left     = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k])
            offer_byte(directed[k], 1'b0);
        wait_drained();

        // Random packets: most headers keep both overflow bits clear so the
        // decode path is reached; twice, hold the receiver off and rush bytes
        // back to back to fill the block and stall its input.
        for (int unsigned p = 0; p < RANDOM_PACKETS; p++) begin
            if (p == 110 || p == 240) begin
                stall_asked <= stall_asked + 1;
                rush_left = RUSH_BYTES;
            end
            hdr = 8'($urandom);
            if ($urandom_range(0, 4) != 0) begin
                hdr[pmpd_pkg::HDR_OVF_X] = 1'b0;
                hdr[pmpd_pkg::HDR_OVF_Y] = 1'b0;
            end
            for (int unsigned k = 0; k < 3; k++) begin
                offer_byte((k == 0) ? hdr : pick_delta(), rush_left > 0);
                if (rush_left > 0) begin
                    rush_left--;
                    if (rush_left == 0)
                        wait_drained();
                end
            end
        end

        // Drain with a limit, let the pipeline settle, then close the books
        s_axis_tvalid <= 1'b0;
        spins = 0;
        @(negedge i_clk);
        while (pending != 0 && spins < 20000) begin
            @(negedge i_clk);
            spins++;
        end
        repeat (8) @(posedge i_clk);
        end_of_test <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS ps2_mouse_packet_decoder_top");
        else
            $display("FAIL ps2_mouse_packet_decoder_top");
        $finish;
    end

endmodule
